@@ rtl/wdb_pkg.sv @@
// ----------------------------------------------------------------------------
// Watchdog bank package
// Shared types and constants for the multi-channel watchdog bank.
// ----------------------------------------------------------------------------
`default_nettype none

package wdb_pkg;

  // Default sizes of the bank.
  localparam int DEF_CHANNELS   = 8;
  localparam int DEF_TICK_BITS  = 32;
  localparam int DEF_COUNT_BITS = 16;

  // Fixed widths of the command and result words.
  localparam int FUNC_W = 3;
  localparam int CHAN_W = 3;
  localparam int TMO_W  = 31;
  localparam int EXP_W  = 16;
  localparam int MASK_W = 8;

  // Command codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 3'd0,
    FN_INIT   = 3'd1,
    FN_START  = 3'd2,
    FN_FEED   = 3'd3,
    FN_STOP   = 3'd4,
    FN_DELETE = 3'd5,
    FN_READ   = 3'd6
  } func_t;

  // Result status codes.
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_INVALID = 1'b1;

  // Per-field write enables of the channel memory.
  typedef struct packed {
    logic timeout;
    logic feed;
    logic count;
  } mem_we_t;

endpackage

`default_nettype wire

@@ rtl/wdb_chan_mem.sv @@
// ----------------------------------------------------------------------------
// Watchdog channel memory
// Timeout, last feed tick and expiry count of every channel, one shared port.
// ----------------------------------------------------------------------------
`default_nettype none

module wdb_chan_mem
  import wdb_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int TICK_BITS  = DEF_TICK_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                  clk,
  input  wire logic [IDX_W-1:0]      addr,
  input  wire mem_we_t               we,
  input  wire logic [TICK_BITS-1:0]  wd_timeout,
  input  wire logic [TICK_BITS-1:0]  wd_feed,
  input  wire logic [COUNT_BITS-1:0] wd_count,
  output logic      [TICK_BITS-1:0]  rd_timeout,
  output logic      [TICK_BITS-1:0]  rd_feed,
  output logic      [COUNT_BITS-1:0] rd_count
);

  logic [TICK_BITS-1:0]  timeout_mem [CHANNELS];
  logic [TICK_BITS-1:0]  feed_mem    [CHANNELS];
  logic [COUNT_BITS-1:0] count_mem   [CHANNELS];

  // Entries are only used after an init has written them, so no reset.
  always_ff @(posedge clk) begin
    if (we.timeout) begin
      timeout_mem[addr] <= wd_timeout;
    end
    if (we.feed) begin
      feed_mem[addr] <= wd_feed;
    end
    if (we.count) begin
      count_mem[addr] <= wd_count;
    end
    rd_timeout <= timeout_mem[addr];
    rd_feed    <= feed_mem[addr];
    rd_count   <= count_mem[addr];
  end

endmodule

`default_nettype wire

@@ rtl/wdb_alu.sv @@
// ----------------------------------------------------------------------------
// Watchdog tick adder
// Shared add/subtract unit for clock advance, deadline and expiry compare.
// ----------------------------------------------------------------------------
`default_nettype none

module wdb_alu
  import wdb_pkg::*;
#(
  parameter int TICK_BITS = DEF_TICK_BITS
) (
  input  wire logic [TICK_BITS-1:0] op_a,
  input  wire logic [TICK_BITS-1:0] op_b,
  input  wire logic                 sub,
  output logic      [TICK_BITS-1:0] result
);

  always_comb begin
    if (sub) begin
      result = op_a - op_b;
    end else begin
      result = op_a + op_b;
    end
  end

endmodule

`default_nettype wire

@@ rtl/multi_channel_watchdog_bank_core.sv @@
// ----------------------------------------------------------------------------
// Multi-channel watchdog bank
// A bank of watchdog channels sharing a tick counter that each tick command advances.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Channel
// commands (init, start, feed, stop, delete, read count) keep busy high
// through a memory read state and an execute state, which registers the
// result word. A tick command first advances the clock and then scans
// every channel in turn (memory read, deadline add, wrap-safe compare and
// write-back); busy stays high until the last channel is compared, and
// the result word is registered from that last compare. This sequencing
// is set by the single port of the channel memory and by the one adder
// that serves the clock advance, the deadline sum and the compare. Each
// result word is shown for exactly one cycle with out_strobe high; the
// receiver cannot stall it, and a new command may be accepted in the same
// cycle the result is shown. A status of one reports an unknown command,
// a channel that is not valid or out of range, or a start with a zero
// timeout. After reset all channels are invalid and the clock is zero; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_watchdog_bank_core
  import wdb_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int TICK_BITS  = DEF_TICK_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [CHAN_W-1:0] in_channel,
  input  wire logic [TMO_W-1:0]  in_timeout,
  output logic                   out_strobe,
  output logic                   out_status,
  output logic      [EXP_W-1:0]  out_expiry_count,
  output logic      [MASK_W-1:0] out_expired_mask
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EXEC,
    S_TICK,
    S_SCAN_RD,
    S_SCAN_ADD,
    S_SCAN_CMP
  } state_t;

  // Sequencer and bank state.
  state_t                state_r, state_nxt;
  logic [CHANNELS-1:0]   valid_r, valid_nxt;
  logic [CHANNELS-1:0]   active_r, active_nxt;
  logic [TICK_BITS-1:0]  tick_now_r, tick_now_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [TICK_BITS-1:0]  dl_r, dl_nxt;
  logic [MASK_W-1:0]     mask_r, mask_nxt;

  // Latched command word.
  logic [FUNC_W-1:0]     func_r, func_nxt;
  logic [IDX_W-1:0]      ch_idx_r, ch_idx_nxt;
  logic                  inrange_r, inrange_nxt;
  logic [TICK_BITS-1:0]  tmo_r, tmo_nxt;

  // Registered result word.
  logic                  strobe_r, strobe_nxt;
  logic                  status_r, status_nxt;
  logic [EXP_W-1:0]      count_r, count_nxt;
  logic [MASK_W-1:0]     omask_r, omask_nxt;

  // Channel memory port.
  logic [IDX_W-1:0]      mem_addr;
  mem_we_t               mem_we;
  logic [TICK_BITS-1:0]  wd_feed;
  logic [COUNT_BITS-1:0] wd_count;
  logic [TICK_BITS-1:0]  rd_timeout;
  logic [TICK_BITS-1:0]  rd_feed;
  logic [COUNT_BITS-1:0] rd_count;

  // Shared adder.
  logic [TICK_BITS-1:0]  alu_a, alu_b, alu_y;
  logic                  alu_sub;

  logic                  accept;
  logic                  chan_ok;
  logic                  scan_hit;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // The scan states walk the channel index; everything else addresses the
  // channel named by the command.
  assign mem_addr = (state_r == S_SCAN_RD || state_r == S_SCAN_ADD ||
                     state_r == S_SCAN_CMP) ? idx_r : ch_idx_r;

  assign chan_ok = inrange_r && valid_r[ch_idx_r];

  // A channel expires when it is armed and (now - deadline) has its top bit
  // clear, which is the wrap-safe form of "now has reached the deadline".
  assign scan_hit = valid_r[idx_r] && active_r[idx_r] && (rd_timeout != '0) &&
                    !alu_y[TICK_BITS-1];

  wdb_chan_mem #(
    .CHANNELS   (CHANNELS),
    .TICK_BITS  (TICK_BITS),
    .COUNT_BITS (COUNT_BITS),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk        (clk),
    .addr       (mem_addr),
    .we         (mem_we),
    .wd_timeout (tmo_r),
    .wd_feed    (wd_feed),
    .wd_count   (wd_count),
    .rd_timeout (rd_timeout),
    .rd_feed    (rd_feed),
    .rd_count   (rd_count)
  );

  wdb_alu #(
    .TICK_BITS (TICK_BITS)
  ) u_alu (
    .op_a   (alu_a),
    .op_b   (alu_b),
    .sub    (alu_sub),
    .result (alu_y)
  );

  // Adder operand selection: clock advance, deadline sum, deadline compare.
  always_comb begin
    alu_a   = tick_now_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_TICK: begin
        alu_b = TICK_BITS'(1);
      end
      S_SCAN_ADD: begin
        alu_a = rd_feed;
        alu_b = rd_timeout;
      end
      S_SCAN_CMP: begin
        alu_b   = dl_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    active_nxt   = active_r;
    tick_now_nxt = tick_now_r;
    idx_nxt      = idx_r;
    dl_nxt       = dl_r;
    mask_nxt     = mask_r;
    func_nxt     = func_r;
    ch_idx_nxt   = ch_idx_r;
    inrange_nxt  = inrange_r;
    tmo_nxt      = tmo_r;
    strobe_nxt   = 1'b0;
    status_nxt   = status_r;
    count_nxt    = count_r;
    omask_nxt    = omask_r;
    mem_we       = '0;
    wd_feed      = tick_now_r;
    wd_count     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt    = in_func;
          ch_idx_nxt  = IDX_W'(in_channel);
          inrange_nxt = (32'(in_channel) < CHANNELS);
          tmo_nxt     = TICK_BITS'(in_timeout);
          if (in_func == FN_TICK) begin
            state_nxt = S_TICK;
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      // The read of the addressed channel is in flight.
      S_RD: begin
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        state_nxt  = S_IDLE;
        strobe_nxt = 1'b1;
        status_nxt = ST_OK;
        count_nxt  = '0;
        omask_nxt  = '0;
        case (func_r)
          FN_INIT: begin
            if (inrange_r) begin
              mem_we                = '{timeout: 1'b1, feed: 1'b1, count: 1'b1};
              valid_nxt[ch_idx_r]   = 1'b1;
              active_nxt[ch_idx_r]  = 1'b0;
            end else begin
              status_nxt = ST_INVALID;
            end
          end
          FN_START: begin
            if (chan_ok && rd_timeout != '0) begin
              mem_we.feed          = 1'b1;
              active_nxt[ch_idx_r] = 1'b1;
            end else begin
              status_nxt = ST_INVALID;
            end
          end
          FN_FEED: begin
            if (chan_ok) begin
              mem_we.feed = 1'b1;
            end else begin
              status_nxt = ST_INVALID;
            end
          end
          FN_STOP: begin
            if (chan_ok) begin
              active_nxt[ch_idx_r] = 1'b0;
            end else begin
              status_nxt = ST_INVALID;
            end
          end
          FN_DELETE: begin
            if (chan_ok) begin
              active_nxt[ch_idx_r] = 1'b0;
              valid_nxt[ch_idx_r]  = 1'b0;
            end else begin
              status_nxt = ST_INVALID;
            end
          end
          FN_READ: begin
            if (chan_ok) begin
              count_nxt = EXP_W'(rd_count);
            end else begin
              status_nxt = ST_INVALID;
            end
          end
          default: begin
            status_nxt = ST_INVALID;
          end
        endcase
      end

      // Advance the clock, then scan from channel zero.
      S_TICK: begin
        tick_now_nxt = alu_y;
        idx_nxt      = '0;
        mask_nxt     = '0;
        state_nxt    = S_SCAN_RD;
      end

      S_SCAN_RD: begin
        state_nxt = S_SCAN_ADD;
      end

      S_SCAN_ADD: begin
        dl_nxt    = alu_y;
        state_nxt = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (scan_hit) begin
          mem_we.feed  = 1'b1;
          mem_we.count = 1'b1;
          // The expiry count saturates; the feed tick is rearmed regardless.
          if (rd_count != '1) begin
            wd_count = rd_count + COUNT_BITS'(1);
          end else begin
            wd_count = rd_count;
          end
          if (32'(idx_r) < MASK_W) begin
            mask_nxt[3'(idx_r)] = 1'b1;
          end
        end
        if (idx_r == IDX_W'(CHANNELS - 1)) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          status_nxt = ST_OK;
          count_nxt  = '0;
          omask_nxt  = mask_nxt;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      active_r   <= '0;
      tick_now_r <= '0;
      idx_r      <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      active_r   <= active_nxt;
      tick_now_r <= tick_now_nxt;
      idx_r      <= idx_nxt;
      strobe_r   <= strobe_nxt;
    end
    dl_r      <= dl_nxt;
    mask_r    <= mask_nxt;
    func_r    <= func_nxt;
    ch_idx_r  <= ch_idx_nxt;
    inrange_r <= inrange_nxt;
    tmo_r     <= tmo_nxt;
    status_r  <= status_nxt;
    count_r   <= count_nxt;
    omask_r   <= omask_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_expiry_count = count_r;
  assign out_expired_mask = omask_r;

endmodule

`default_nettype wire

@@ rtl/wdb_checker.sv @@
// ----------------------------------------------------------------------------
// Watchdog bank checker
// Port-level assertions on the command and result timing of the bank.
// ----------------------------------------------------------------------------
`default_nettype none

module wdb_checker
  import wdb_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [FUNC_W-1:0] in_func,
  input wire logic              out_strobe,
  input wire logic              out_status,
  input wire logic [EXP_W-1:0]  out_expiry_count,
  input wire logic [MASK_W-1:0] out_expired_mask
);

  // An accepted command always makes the bank busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("bank not busy after accepting a command");

  // A channel command shows its result word after its read and execute states.
  a_chan_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func != FN_TICK) |-> ##3 out_strobe)
    else $error("channel command result missing");

  // A result word is never shown while the bank is still working.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  // A result word lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  // A result with a nonzero expiry count, which only a read gives, carries no expiry mask and reports success.
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_expiry_count != '0) |->
      (out_expired_mask == '0 && out_status == ST_OK))
    else $error("inconsistent read result");

endmodule

bind multi_channel_watchdog_bank_core wdb_checker u_wdb_checker (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Watchdog bank testbench
// Drives command words into the bank and checks every result word against
// a typed value or a cycle-free model of the channel bank kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import wdb_pkg::*;

  // The selector value that no command uses; the block must reject it.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int NUM_CHANNELS = DEF_CHANNELS;
  localparam logic [EXP_W-1:0] COUNT_MAX = '1;
  localparam logic [TMO_W-1:0] TMO_MAX = '1;
  // Longest busy stretch of a tick scan plus slack, in cycles.
  localparam int SCAN_CYCLES = 3 * NUM_CHANNELS + 2;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic              status;
    logic [EXP_W-1:0]  count;
    logic [MASK_W-1:0] mask;
  } result_t;

  // One row of the directed stimulus. Rows with a pinned result are checked
  // against the typed value; all others against the bank model.
  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [CHAN_W-1:0] chan;
    logic [TMO_W-1:0]  tmo;
    bit                pinned;
    result_t           want;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [FUNC_W-1:0] in_func;
  logic [CHAN_W-1:0] in_channel;
  logic [TMO_W-1:0]  in_timeout;
  logic              out_strobe;
  logic              out_status;
  logic [EXP_W-1:0]  out_expiry_count;
  logic [MASK_W-1:0] out_expired_mask;

  multi_channel_watchdog_bank_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_channel       (in_channel),
    .in_timeout       (in_timeout),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_expiry_count (out_expiry_count),
    .out_expired_mask (out_expired_mask)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A run that has not finished by this bound is ended as failed.
  initial begin
    #1_000_000;
    $display("** multi_channel_watchdog_bank_core: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Bank model: the tick clock and the per-channel records.
  // --------------------------------------------------------------------------
  logic [31:0]      now_tick;
  logic [31:0]      ch_timeout [NUM_CHANNELS];
  logic [31:0]      ch_fed     [NUM_CHANNELS];
  logic [EXP_W-1:0] ch_count   [NUM_CHANNELS];
  bit               ch_active  [NUM_CHANNELS];
  bit               ch_valid   [NUM_CHANNELS];

  result_t pending_results [$];
  int      err_count;
  int      word_index;

  // The driver hands a typed expectation to the monitor through these.
  bit      pin_valid;
  result_t pin_result;

  // Applies one command word to the bank model and returns the result word
  // that the block must produce for it.
  function automatic result_t apply_command(input logic [FUNC_W-1:0] f,
                                            input logic [CHAN_W-1:0] c,
                                            input logic [TMO_W-1:0] t);
    result_t     r;
    logic [31:0] deadline;
    logic [31:0] lag;
    bit          ok;
    r = '0;
    ok = ch_valid[c];
    case (f)
      FN_TICK: begin
        now_tick = now_tick + 32'd1;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (ch_valid[i] && ch_active[i] && ch_timeout[i] != 32'd0) begin
            // The deadline counts as reached while the clock is less than
            // half a wrap past it.
            deadline = ch_fed[i] + ch_timeout[i];
            lag = now_tick - deadline;
            if (!lag[31]) begin
              if (ch_count[i] != COUNT_MAX) ch_count[i] = ch_count[i] + 1'b1;
              ch_fed[i] = now_tick;
              r.mask[i] = 1'b1;
            end
          end
        end
      end
      FN_INIT: begin
        ch_timeout[c] = {1'b0, t};
        ch_fed[c]     = now_tick;
        ch_count[c]   = '0;
        ch_active[c]  = 1'b0;
        ch_valid[c]   = 1'b1;
      end
      FN_START: begin
        if (ok && ch_timeout[c] != 32'd0) begin
          ch_fed[c]    = now_tick;
          ch_active[c] = 1'b1;
        end else begin
          r.status = ST_INVALID;
        end
      end
      FN_FEED: begin
        if (ok) ch_fed[c] = now_tick;
        else r.status = ST_INVALID;
      end
      FN_STOP: begin
        if (ok) ch_active[c] = 1'b0;
        else r.status = ST_INVALID;
      end
      FN_DELETE: begin
        if (ok) begin
          ch_active[c] = 1'b0;
          ch_valid[c]  = 1'b0;
        end else begin
          r.status = ST_INVALID;
        end
      end
      FN_READ: begin
        if (ok) r.count = ch_count[c];
        else r.status = ST_INVALID;
      end
      default: r.status = ST_INVALID;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_count < MAX_PRINTS) $display("MISMATCH word %0d: %s", word_index, what);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor: checks the result word shown in this cycle, then records the
  // expectation of a command word accepted at this edge. A result may share
  // its cycle with the next acceptance, so the check comes first.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    result_t model;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0b want %0b", out_status, want.status));
          if (out_expiry_count !== want.count)
            report_mismatch($sformatf("expiry_count got %0d want %0d",
                                      out_expiry_count, want.count));
          if (out_expired_mask !== want.mask)
            report_mismatch($sformatf("expired_mask got %02h want %02h",
                                      out_expired_mask, want.mask));
        end
        word_index++;
      end
      if (start && !busy) begin
        model = apply_command(in_func, in_channel, in_timeout);
        pending_results.push_back(pin_valid ? pin_result : model);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. Inputs move only at the falling edge. Busy changes only at
  // the rising edge, so its value at the falling edge decides whether the
  // next rising edge takes the word.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [CHAN_W-1:0] c,
                           input logic [TMO_W-1:0] t, input bit pinned,
                           input result_t want);
    @(negedge clk);
    start      <= 1'b1;
    in_func    <= f;
    in_channel <= c;
    in_timeout <= t;
    pin_valid  = pinned;
    pin_result = want;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Drives start low; the fields carry noise the block must ignore.
  task automatic idle_cycle();
    @(negedge clk);
    start      <= 1'b0;
    in_func    <= FUNC_W'($urandom_range(0, 7));
    in_channel <= CHAN_W'($urandom_range(0, 7));
    in_timeout <= TMO_W'($urandom());
  endtask

  task automatic wait_drained();
    idle_cycle();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed channel traffic with small timeouts so that channels
  // really expire; a few words carry huge timeouts or the unused selector.
  task automatic send_random();
    int                sel;
    int                tsel;
    logic [FUNC_W-1:0] f;
    logic [TMO_W-1:0]  t;
    sel = $urandom_range(0, 99);
    if (sel < 36) f = FN_TICK;
    else if (sel < 46) f = FN_INIT;
    else if (sel < 58) f = FN_START;
    else if (sel < 70) f = FN_FEED;
    else if (sel < 76) f = FN_STOP;
    else if (sel < 80) f = FN_DELETE;
    else if (sel < 97) f = FN_READ;
    else f = FN_UNUSED;
    tsel = $urandom_range(0, 99);
    if (tsel < 8) t = '0;
    else if (tsel < 80) t = TMO_W'($urandom_range(1, 12));
    else if (tsel < 92) t = TMO_W'($urandom());
    else t = TMO_MAX;
    send_word(f, CHAN_W'($urandom_range(0, 7)), t, 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Directed rows.
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [$];

  task automatic add_row(input logic [FUNC_W-1:0] f, input logic [CHAN_W-1:0] c,
                         input logic [TMO_W-1:0] t, input bit pinned,
                         input logic st, input logic [EXP_W-1:0] cnt,
                         input logic [MASK_W-1:0] mask);
    stim_row_t row;
    row.func   = f;
    row.chan   = c;
    row.tmo    = t;
    row.pinned = pinned;
    row.want   = '{status: st, count: cnt, mask: mask};
    directed_rows.push_back(row);
  endtask

  initial begin
    int idle_pct;
    int guard;
    err_count  = 0;
    word_index = 0;
    pin_valid  = 1'b0;
    pin_result = '0;
    now_tick   = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      ch_timeout[i] = '0;
      ch_fed[i]     = '0;
      ch_count[i]   = '0;
      ch_active[i]  = 1'b0;
      ch_valid[i]   = 1'b0;
    end
    rst_n      = 1'b0;
    start      = 1'b0;
    in_func    = '0;
    in_channel = '0;
    in_timeout = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // After reset nothing is valid: every channel command is rejected and a
    // tick expires nothing.
    add_row(FN_READ,   3'd0, '0,      1'b1, ST_INVALID, '0, '0);
    add_row(FN_TICK,   3'd5, TMO_MAX, 1'b1, ST_OK,      '0, '0);
    add_row(FN_START,  3'd0, 31'd5,   1'b1, ST_INVALID, '0, '0);
    add_row(FN_FEED,   3'd7, '0,      1'b1, ST_INVALID, '0, '0);
    add_row(FN_STOP,   3'd3, '0,      1'b1, ST_INVALID, '0, '0);
    add_row(FN_DELETE, 3'd5, '0,      1'b1, ST_INVALID, '0, '0);
    add_row(FN_UNUSED, 3'd0, '0,      1'b1, ST_INVALID, '0, '0);
    // A channel set up with a zero timeout cannot be started.
    add_row(FN_INIT,   3'd0, '0,      1'b1, ST_OK,      '0, '0);
    add_row(FN_START,  3'd0, '0,      1'b1, ST_INVALID, '0, '0);
    add_row(FN_INIT,   3'd1, 31'd1,   1'b1, ST_OK,      '0, '0);
    add_row(FN_START,  3'd1, '0,      1'b1, ST_OK,      '0, '0);
    add_row(FN_TICK,   3'd0, '0,      1'b0, ST_OK,      '0, '0);
    add_row(FN_TICK,   3'd0, '0,      1'b0, ST_OK,      '0, '0);
    add_row(FN_READ,   3'd1, '0,      1'b0, ST_OK,      '0, '0);
    // The largest timeout never comes due within the run.
    add_row(FN_INIT,   3'd7, TMO_MAX, 1'b1, ST_OK,      '0, '0);
    add_row(FN_START,  3'd7, '0,      1'b1, ST_OK,      '0, '0);
    add_row(FN_INIT,   3'd2, 31'd2,   1'b1, ST_OK,      '0, '0);
    add_row(FN_START,  3'd2, '0,      1'b0, ST_OK,      '0, '0);
    add_row(FN_TICK,   3'd0, '0,      1'b0, ST_OK,      '0, '0);
    add_row(FN_FEED,   3'd2, '0,      1'b0, ST_OK,      '0, '0);
    add_row(FN_STOP,   3'd1, '0,      1'b0, ST_OK,      '0, '0);
    add_row(FN_TICK,   3'd0, '0,      1'b0, ST_OK,      '0, '0);
    add_row(FN_READ,   3'd1, '0,      1'b0, ST_OK,      '0, '0);
    add_row(FN_DELETE, 3'd2, '0,      1'b1, ST_OK,      '0, '0);
    add_row(FN_READ,   3'd2, TMO_MAX, 1'b1, ST_INVALID, '0, '0);
    add_row(FN_UNUSED, 3'd7, TMO_MAX, 1'b1, ST_INVALID, '0, '0);
    foreach (directed_rows[i])
      send_word(directed_rows[i].func, directed_rows[i].chan, directed_rows[i].tmo,
                directed_rows[i].pinned, directed_rows[i].want);

    // The sender holds off here until every outstanding word has come back.
    wait_drained();

    // Random traffic under three idling regimes: light, heavy, none.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 35 : (phase == 1) ? 74 : 0;
      for (int n = 0; n < 300; n++) begin
        while ($urandom_range(0, 99) < idle_pct) idle_cycle();
        send_random();
      end
      wait_drained();
    end

    idle_cycle();
    guard = 0;
    while (pending_results.size() != 0 && guard < 20 * SCAN_CYCLES) begin
      @(negedge clk);
      guard++;
    end
    // Let any stray result word show itself before the verdict.
    repeat (2 * SCAN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", pending_results.size()));

    if (err_count == 0) begin
      $display("** multi_channel_watchdog_bank_core: PASSED **");
    end else begin
      $display("** multi_channel_watchdog_bank_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
